// ===== src/sprng_pkg.sv =====
// Shared types, constants and helpers for the stopping power range integrator.
`default_nettype none
package sprng_pkg;

  localparam logic [31:0] K_Q32      = 32'd1318877082;
  localparam logic [27:0] LN2_Q28    = 28'd186065280;
  localparam logic [31:0] TWO_ME_EV8 = 32'd261632000;

  typedef enum logic [2:0] {
    REG_DENSITY    = 3'd0,
    REG_STEP       = 3'd1,
    REG_CUTOFF     = 3'd2,
    REG_LIMIT      = 3'd3,
    REG_EXCITATION = 3'd4,
    REG_ZOA        = 3'd5,
    REG_MASS       = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    LS_TM,
    LS_IP,
    LS_GB
  } log_sel_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_FIRST,
    ST_K_GO, ST_K_W, ST_D_GO, ST_D_W,
    ST_LG_NORM, ST_LG_PREP, ST_LG_SQ_GO, ST_LG_SQ_W, ST_LG_END,
    ST_U_GO, ST_U_W, ST_GB_GO, ST_GB_W, ST_R_GO, ST_R_W, ST_R2_GO, ST_R2_W,
    ST_B2_GO, ST_B2_W, ST_LN_GO, ST_LN_W, ST_C_GO, ST_C_W,
    ST_Q_GO, ST_Q_W, ST_F_GO, ST_F_W, ST_LS_GO, ST_LS_W,
    ST_PART_GO, ST_PART_W, ST_ZL_GO, ST_ZL_W, ST_ZM_GO, ST_ZM_W, ST_CHK
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // (product >> 32), saturating to 64 bits
  function automatic logic [63:0] sat_shr32(input logic [127:0] p);
    sat_shr32 = (p[127:96] != 32'd0) ? {64{1'b1}} : p[95:32];
  endfunction

  // (product >> 28), saturating to 64 bits
  function automatic logic [63:0] sat_shr28(input logic [127:0] p);
    sat_shr28 = (p[127:92] != 36'd0) ? {64{1'b1}} : p[91:28];
  endfunction

endpackage
`default_nettype wire

// ===== src/sprng_mul.sv =====
// Iterative 64x64 multiplier built on one 32x32 multiplier, four partial products.
`default_nettype none
module sprng_mul import sprng_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic      [127:0] prod,
  output unit_stat_t        stat
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         done;
  logic [31:0]  ah;
  logic [31:0]  bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign ah = cnt[1] ? a_r[63:32] : a_r[31:0];
  assign bh = cnt[0] ? b_r[63:32] : b_r[31:0];
  assign pp = {32'd0, ah} * {32'd0, bh};

  always_comb begin
    case (cnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        acc  <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// ===== src/sprng_div.sv =====
// Restoring 64/64 divider, one quotient bit per cycle.
`default_nettype none
module sprng_div import sprng_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic      [63:0] quot,
  output logic      [63:0] rem,
  output unit_stat_t       stat
);

  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] d_r;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [65:0] diff;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign diff = {1'b0, r, q[63]} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        r    <= '0;
        d_r  <= divisor;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        q <= {q[62:0], ~diff[65]};
        if (!diff[65]) begin
          r <= diff[63:0];
        end else begin
          r <= {r[62:0], q[63]};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot      = q;
  assign rem       = r;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// ===== src/stopping_power_range_integrator.sv =====
// Top level: sequencer of the range integrator with its shared multiplier and divider.
// Sequence: done follows directly from the first check when the energy is at or below cutoff;
// otherwise a per-item setup (two logarithms and two products) runs first, then each
// integration step runs at most four divisions and one logarithm along with its products,
// a last partial step one more division, and the zero-loss jump to the limit a division and a product.
// Throughput: one request at a time; busy drops as done pulses, and the receiver cannot stall.
// Reset (rst, synchronous) returns the sequencer to idle and loads register defaults.
`default_nettype none
module stopping_power_range_integrator import sprng_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [25:0] initial_energy,
  output logic             busy,
  output logic             done,
  output logic      [30:0] range_distance,
  output logic             hit_limit,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic signed [36:0] L2_OFFSET = 37'sd8589934592;
  localparam logic [63:0]        TWO33     = 64'h2_0000_0000;
  localparam logic [63:0]        ONE_Q32   = 64'h1_0000_0000;

  // configuration registers
  logic [31:0] density;
  logic [19:0] step_length;
  logic [25:0] cutoff_energy;
  logic [30:0] distance_limit;
  logic [18:0] excitation_potential;
  logic [16:0] charge_over_mass;
  logic [31:0] projectile_mass;

  logic [31:0] mp_e;
  logic [18:0] ip_e;
  logic [19:0] step_e;
  reg_idx_t    widx;
  logic        wr_en;

  state_t state, state_next;

  logic [25:0]        e;
  logic [31:0]        trav;
  logic [31:0]        bcoef;
  logic [63:0]        x0;
  logic [31:0]        xr;
  logic [63:0]        gb2;
  logic [32:0]        b2;
  logic [63:0]        s;
  logic [33:0]        ltm;
  logic signed [36:0] lc;
  logic               lneg;
  log_sel_t           lsel;
  logic [63:0]        lx;
  logic [5:0]         lz;
  logic [2:0]         lcnt;
  logic [31:0]        lm;
  logic [33:0]        lf;
  logic [4:0]         lbit;

  logic               mul_start;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic [127:0]       mprod;
  unit_stat_t         mstat;
  logic               div_start;
  logic [63:0]        div_n;
  logic [63:0]        div_d;
  logic [63:0]        dquot;
  logic [63:0]        drem;
  unit_stat_t         dstat;

  logic [63:0]        loss;
  logic [63:0]        b2_full;
  logic [32:0]        b2v;
  logic signed [36:0] l2;
  logic signed [36:0] l2_neg;
  logic [35:0]        l2_mag;
  logic [35:0]        ln_mag;
  logic signed [36:0] ln;
  logic signed [37:0] term;
  logic               term_pos;
  logic [32:0]        sq;
  logic [31:0]        trav_next;

  assign mp_e   = (projectile_mass == 32'd0) ? 32'd1 : projectile_mass;
  assign ip_e   = (excitation_potential == 19'd0) ? 19'd1 : excitation_potential;
  assign step_e = (step_length == 20'd0) ? 20'd1 : step_length;

  // configuration port
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      density              <= 32'd141987;
      step_length          <= 20'd6554;
      cutoff_energy        <= 26'd655;
      distance_limit       <= 31'd1310720000;
      excitation_potential <= 19'd4915;
      charge_over_mass     <= 17'd65023;
      projectile_mass      <= 32'd61490463;
    end else if (wr_en) begin
      case (widx)
        REG_DENSITY:    density              <= pwdata;
        REG_STEP:       step_length          <= pwdata[19:0];
        REG_CUTOFF:     cutoff_energy        <= pwdata[25:0];
        REG_LIMIT:      distance_limit       <= pwdata[30:0];
        REG_EXCITATION: excitation_potential <= pwdata[18:0];
        REG_ZOA:        charge_over_mass     <= pwdata[16:0];
        REG_MASS:       projectile_mass      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_DENSITY:    prdata = density;
      REG_STEP:       prdata = {12'd0, step_length};
      REG_CUTOFF:     prdata = {6'd0, cutoff_energy};
      REG_LIMIT:      prdata = {1'b0, distance_limit};
      REG_EXCITATION: prdata = {13'd0, excitation_potential};
      REG_ZOA:        prdata = {15'd0, charge_over_mass};
      REG_MASS:       prdata = projectile_mass;
      default:        prdata = 32'd0;
    endcase
  end

  // shared units
  sprng_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mprod),
    .stat  (mstat)
  );

  sprng_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (dquot),
    .rem      (drem),
    .stat     (dstat)
  );

  // result decoding
  assign loss     = sat_shr32(mprod);
  assign b2_full  = sat_shr32(mprod);
  assign b2v      = (b2_full > ONE_Q32) ? ONE_Q32[32:0] : b2_full[32:0];
  assign l2       = $signed({3'b000, lf}) - L2_OFFSET + lc;
  assign l2_neg   = -l2;
  assign l2_mag   = l2[36] ? l2_neg[35:0] : l2[35:0];
  assign ln_mag   = mprod[63:28];
  assign ln       = lneg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
  assign term     = $signed({ln[36], ln}) - $signed({9'd0, b2[32:4]});
  assign term_pos = !term[37] && (term != 38'sd0);
  assign sq       = mprod[63:31];
  assign trav_next = trav + {12'd0, step_e};

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit requests
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    case (state)
      ST_IDLE:     if (start) state_next = ST_FIRST;
      ST_FIRST:    state_next = (e > cutoff_energy) ? ST_K_GO : ST_IDLE;
      ST_K_GO: begin
        mul_start = 1'b1;
        mul_a = {32'd0, K_Q32};
        mul_b = {47'd0, charge_over_mass};
        state_next = ST_K_W;
      end
      ST_K_W:      if (mstat.done) state_next = ST_D_GO;
      ST_D_GO: begin
        mul_start = 1'b1;
        mul_a = x0;
        mul_b = {32'd0, density};
        state_next = ST_D_W;
      end
      ST_D_W:      if (mstat.done) state_next = ST_LG_NORM;
      ST_LG_NORM:  if (lcnt == 3'd5) state_next = ST_LG_PREP;
      ST_LG_PREP:  state_next = ST_LG_SQ_GO;
      ST_LG_SQ_GO: begin
        mul_start = 1'b1;
        mul_a = {32'd0, lm};
        mul_b = {32'd0, lm};
        state_next = ST_LG_SQ_W;
      end
      ST_LG_SQ_W: begin
        if (mstat.done) begin
          state_next = (lbit == 5'd0) ? ST_LG_END : ST_LG_SQ_GO;
        end
      end
      ST_LG_END: begin
        case (lsel)
          LS_TM:   state_next = ST_LG_NORM;
          LS_IP:   state_next = ST_U_GO;
          default: state_next = ST_LN_GO;
        endcase
      end
      ST_U_GO: begin
        div_start = 1'b1;
        div_n = {6'd0, e, 32'd0};
        div_d = {32'd0, mp_e};
        state_next = ST_U_W;
      end
      ST_U_W:      if (dstat.done) state_next = ST_GB_GO;
      ST_GB_GO: begin
        mul_start = 1'b1;
        mul_a = x0;
        mul_b = x0 + TWO33;
        state_next = ST_GB_W;
      end
      ST_GB_W:     if (mstat.done) state_next = ST_R_GO;
      ST_R_GO: begin
        div_start = 1'b1;
        div_n = {mp_e, 32'd0};
        div_d = {32'd0, mp_e} + {38'd0, e};
        state_next = ST_R_W;
      end
      ST_R_W:      if (dstat.done) state_next = ST_R2_GO;
      ST_R2_GO: begin
        mul_start = 1'b1;
        mul_a = x0;
        mul_b = x0;
        state_next = ST_R2_W;
      end
      ST_R2_W:     if (mstat.done) state_next = ST_B2_GO;
      ST_B2_GO: begin
        mul_start = 1'b1;
        mul_a = gb2;
        mul_b = x0;
        state_next = ST_B2_W;
      end
      ST_B2_W: begin
        if (mstat.done) begin
          state_next = (b2v == 33'd0 || gb2 == 64'd0) ? ST_LS_GO : ST_LG_NORM;
        end
      end
      ST_LN_GO: begin
        mul_start = 1'b1;
        mul_a = x0;
        mul_b = {36'd0, LN2_Q28};
        state_next = ST_LN_W;
      end
      ST_LN_W:     if (mstat.done) state_next = term_pos ? ST_C_GO : ST_LS_GO;
      ST_C_GO: begin
        mul_start = 1'b1;
        mul_a = {32'd0, bcoef};
        mul_b = x0;
        state_next = ST_C_W;
      end
      ST_C_W:      if (mstat.done) state_next = ST_Q_GO;
      ST_Q_GO: begin
        div_start = 1'b1;
        div_n = x0;
        div_d = {31'd0, b2};
        state_next = ST_Q_W;
      end
      ST_Q_W: begin
        if (dstat.done) begin
          state_next = (dquot[63:32] != 32'd0) ? ST_LS_GO : ST_F_GO;
        end
      end
      ST_F_GO: begin
        div_start = 1'b1;
        div_n = {xr, 32'd0};
        div_d = {31'd0, b2};
        state_next = ST_F_W;
      end
      ST_F_W:      if (dstat.done) state_next = ST_LS_GO;
      ST_LS_GO: begin
        mul_start = 1'b1;
        mul_a = s;
        mul_b = {44'd0, step_e};
        state_next = ST_LS_W;
      end
      ST_LS_W: begin
        if (mstat.done) begin
          if (loss > {38'd0, e}) begin
            state_next = ST_PART_GO;
          end else if (loss == 64'd0) begin
            state_next = ST_ZL_GO;
          end else begin
            state_next = ST_CHK;
          end
        end
      end
      ST_PART_GO: begin
        div_start = 1'b1;
        div_n = {6'd0, e, 32'd0};
        div_d = s;
        state_next = ST_PART_W;
      end
      ST_PART_W:   if (dstat.done) state_next = ST_CHK;
      ST_ZL_GO: begin
        div_start = 1'b1;
        div_n = {32'd0, {1'b0, distance_limit} - trav};
        div_d = {44'd0, step_e};
        state_next = ST_ZL_W;
      end
      ST_ZL_W:     if (dstat.done) state_next = ST_ZM_GO;
      ST_ZM_GO: begin
        mul_start = 1'b1;
        mul_a = x0;
        mul_b = {44'd0, step_e};
        state_next = ST_ZM_W;
      end
      ST_ZM_W:     if (mstat.done) state_next = ST_CHK;
      ST_CHK: begin
        if (trav > {1'b0, distance_limit}) begin
          state_next = ST_IDLE;
        end else if (e > cutoff_energy) begin
          state_next = ST_U_GO;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_FIRST) && !(e > cutoff_energy))
           || ((state == ST_CHK) && (state_next == ST_IDLE));
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          e    <= initial_energy;
          trav <= 32'd0;
        end
      end
      ST_FIRST: begin
        if (!(e > cutoff_energy)) begin
          range_distance <= 31'd0;
          hit_limit      <= 1'b0;
        end
      end
      ST_K_W:  if (mstat.done) x0 <= {32'd0, mprod[47:16]};
      ST_D_W: begin
        if (mstat.done) begin
          bcoef <= mprod[63:32];
          lx    <= {32'd0, TWO_ME_EV8};
          lsel  <= LS_TM;
          lz    <= 6'd0;
          lcnt  <= 3'd0;
        end
      end
      ST_LG_NORM: begin
        lcnt <= lcnt + 3'd1;
        case (lcnt)
          3'd0: if (lx[63:32] == 32'd0) begin lx <= {lx[31:0], 32'd0}; lz <= lz + 6'd32; end
          3'd1: if (lx[63:48] == 16'd0) begin lx <= {lx[47:0], 16'd0}; lz <= lz + 6'd16; end
          3'd2: if (lx[63:56] == 8'd0) begin lx <= {lx[55:0], 8'd0}; lz <= lz + 6'd8; end
          3'd3: if (lx[63:60] == 4'd0) begin lx <= {lx[59:0], 4'd0}; lz <= lz + 6'd4; end
          3'd4: if (lx[63:62] == 2'd0) begin lx <= {lx[61:0], 2'd0}; lz <= lz + 6'd2; end
          3'd5: if (!lx[63]) begin lx <= {lx[62:0], 1'b0}; lz <= lz + 6'd1; end
          default: ;
        endcase
      end
      ST_LG_PREP: begin
        lm   <= lx[63:32];
        lf   <= {~lz, 28'd0};
        lbit <= 5'd27;
      end
      ST_LG_SQ_W: begin
        if (mstat.done) begin
          if (sq[32]) begin
            lm <= sq[32:1];
            lf <= lf | (34'd1 << lbit);
          end else begin
            lm <= sq[31:0];
          end
          lbit <= lbit - 5'd1;
        end
      end
      ST_LG_END: begin
        case (lsel)
          LS_TM: begin
            ltm  <= lf;
            lx   <= {45'd0, ip_e};
            lsel <= LS_IP;
            lz   <= 6'd0;
            lcnt <= 3'd0;
          end
          LS_IP: lc <= $signed({3'b000, ltm}) - $signed({3'b000, lf});
          default: begin
            x0   <= {28'd0, l2_mag};
            lneg <= l2[36];
          end
        endcase
      end
      ST_U_W:  if (dstat.done) x0 <= dquot;
      ST_GB_W: if (mstat.done) gb2 <= sat_shr32(mprod);
      ST_R_W:  if (dstat.done) x0 <= dquot;
      ST_R2_W: if (mstat.done) x0 <= sat_shr32(mprod);
      ST_B2_W: begin
        if (mstat.done) begin
          b2 <= b2v;
          if (b2v == 33'd0 || gb2 == 64'd0) begin
            s <= 64'd0;
          end else begin
            lx   <= gb2;
            lsel <= LS_GB;
            lz   <= 6'd0;
            lcnt <= 3'd0;
          end
        end
      end
      ST_LN_W: begin
        if (mstat.done) begin
          if (term_pos) begin
            x0 <= {28'd0, term[35:0]};
          end else begin
            s <= 64'd0;
          end
        end
      end
      ST_C_W:  if (mstat.done) x0 <= sat_shr28(mprod);
      ST_Q_W: begin
        if (dstat.done) begin
          if (dquot[63:32] != 32'd0) begin
            s <= {64{1'b1}};
          end else begin
            x0 <= dquot;
            xr <= drem[31:0];
          end
        end
      end
      ST_F_W:  if (dstat.done) s <= {x0[31:0], dquot[31:0]};
      ST_LS_W: begin
        if (mstat.done && !(loss > {38'd0, e}) && (loss != 64'd0)) begin
          e    <= e - loss[25:0];
          trav <= trav_next;
        end
      end
      ST_PART_W: begin
        if (dstat.done) begin
          trav <= trav + dquot[31:0];
          e    <= 26'd0;
        end
      end
      ST_ZL_W: if (dstat.done) x0 <= dquot + 64'd1;
      ST_ZM_W: if (mstat.done) trav <= trav + mprod[31:0];
      ST_CHK: begin
        if (state_next == ST_IDLE) begin
          range_distance <= trav[31] ? {31{1'b1}} : trav[30:0];
          hit_limit      <= (trav > {1'b0, distance_limit});
        end
      end
      default: ;
    endcase
  end

  // the two shared units never run at the same time
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mstat.busy && dstat.busy))
    else $error("multiplier and divider busy together");

  // an accepted request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // leaving busy always delivers a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // the result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire
